@@ hw/rtl/irrac_pkg.sv @@
package irrac_pkg;

    // Frame limits
    localparam int MAX_EDGES   = 32;
    localparam int EDGE_CNT_W  = $clog2(MAX_EDGES + 1);

    // Field widths
    localparam int CMD_W       = 2;
    localparam int TIME_W      = 32;
    localparam int KNOB_W      = 5;
    localparam int WIN_W       = 16;
    localparam int CODE_W      = 32;
    localparam int LEVEL_W     = 2;
    localparam int SPEED_W     = 3;
    localparam int BTN_W       = 3;
    localparam int KNOB_POS_W  = 2;

    // Drive level bit positions
    localparam int PIN_SWING   = 0;
    localparam int PIN_PUMP    = 1;
    localparam int PIN_SPD_LO  = 2;

    // Configuration port
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    // Register reset values
    localparam logic [WIN_W-1:0] ZERO_CENTER_RST = 16'd420;
    localparam logic [WIN_W-1:0] ZERO_TOL_RST    = 16'd150;
    localparam logic [WIN_W-1:0] ONE_CENTER_RST  = 16'd1200;
    localparam logic [WIN_W-1:0] ONE_TOL_RST     = 16'd240;

    // Commands on the input channel
    typedef enum logic [CMD_W-1:0] {
        CMD_EDGE      = 2'd0,
        CMD_FRAME_END = 2'd1,
        CMD_KNOB      = 2'd2
    } cmd_t;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ZERO_CENTER = 3'd0,
        CFG_ZERO_TOL    = 3'd1,
        CFG_ONE_CENTER  = 3'd2,
        CFG_ONE_TOL     = 3'd3,
        CFG_POWER_CODE  = 3'd4,
        CFG_PUMP_CODE   = 3'd5,
        CFG_SWING_CODE  = 3'd6,
        CFG_SPEED_CODE  = 3'd7
    } cfg_idx_t;

    // Decoded button
    typedef enum logic [BTN_W-1:0] {
        BTN_NONE  = 3'd0,
        BTN_POWER = 3'd1,
        BTN_PUMP  = 3'd2,
        BTN_SWING = 3'd3,
        BTN_SPEED = 3'd4
    } btn_t;

    // Register file contents
    typedef struct packed {
        logic [WIN_W-1:0]  zero_center;
        logic [WIN_W-1:0]  zero_tol;
        logic [WIN_W-1:0]  one_center;
        logic [WIN_W-1:0]  one_tol;
        logic [CODE_W-1:0] power_code;
        logic [CODE_W-1:0] pump_code;
        logic [CODE_W-1:0] swing_code;
        logic [CODE_W-1:0] speed_code;
    } cfg_t;

    // Frame summary from the decoder
    typedef struct packed {
        logic              done;
        logic [CODE_W-1:0] code;
        logic              error;
    } frame_info_t;

    // Item held in the input stage
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [TIME_W-1:0] edge_time_us;
        logic [KNOB_W-1:0] knob_pins;
    } item_t;

endpackage

@@ hw/rtl/irrac_in_if.sv @@
interface irrac_in_if
    import irrac_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [TIME_W-1:0] edge_time_us;
    logic [KNOB_W-1:0] knob_pins;

    modport source (output valid, command, edge_time_us, knob_pins, input ready);
    modport sink   (input valid, command, edge_time_us, knob_pins, output ready);
endinterface

@@ hw/rtl/irrac_out_if.sv @@
interface irrac_out_if
    import irrac_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               swing_pin;
    logic               pump_pin;
    logic [SPEED_W-1:0] speed_pins;
    logic               beep;
    logic               frame_done;
    logic [CODE_W-1:0]  frame_code;
    logic               frame_error;
    logic [BTN_W-1:0]   button;

    modport source (output valid, swing_pin, pump_pin, speed_pins, beep, frame_done,
                    frame_code, frame_error, button, input ready);
    modport sink   (input valid, swing_pin, pump_pin, speed_pins, beep, frame_done,
                    frame_code, frame_error, button, output ready);
endinterface

@@ hw/rtl/ir_remote_appliance_controller_unit.sv @@
// IR remote appliance controller.
// Input channel in_ch carries one item per transfer: command (0 IR edge timestamp,
// 1 end of IR frame, 2 knob pin sample), edge_time_us and knob_pins. Every item,
// the unused command code included, gives exactly one result on out_ch: pin levels
// (swing, pump, three speed drives), a buzzer request, and for frame ends the
// shifted code, error flag and matched button.
// Registers are written through cfg_we / cfg_index / cfg_data; the user must write
// them only while idle; the block leaves this unchecked. Pipeline: an input stage
// register, then one pass of window compares, shift, code match and knob decode
// into the result register. Throughput is one item per cycle while out_ch accepts
// results, with the decoder and pin state updated in the second stage.
// When out_ch stalls, the result register holds and the input stage still takes
// one more item; in_ch.ready drops only when both stages are full.
// Reset clears the valid flags and decoder and drive state and loads the default
// windows (zero 420 +/- 150 us, one 1200 +/- 240 us); button codes reset to zero.
module ir_remote_appliance_controller_unit
    import irrac_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    irrac_in_if.sink              in_ch,
    irrac_out_if.source           out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t        cfg;
    frame_info_t frame;
    item_t       item_reg;
    logic        s1_valid_reg;
    logic        s1_fire;
    logic        in_fire;

    logic [KNOB_W-1:0] drive;
    logic              beep;
    btn_t              button;

    logic               out_valid_reg;
    logic               swing_reg;
    logic               pump_reg;
    logic [SPEED_W-1:0] speed_reg;
    logic               beep_reg;
    logic               done_reg;
    logic [CODE_W-1:0]  code_reg;
    logic               error_reg;
    logic [BTN_W-1:0]   button_reg;

    // Stage handshakes
    assign s1_fire     = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || s1_fire;
    assign in_fire     = in_ch.valid && in_ch.ready;

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ch.ready)
            s1_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg.command      <= in_ch.command;
            item_reg.edge_time_us <= in_ch.edge_time_us;
            item_reg.knob_pins    <= in_ch.knob_pins;
        end
    end

    irrac_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    irrac_ir_decoder u_dec (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (s1_fire),
        .item  (item_reg),
        .cfg   (cfg),
        .frame (frame)
    );

    irrac_appliance_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (s1_fire),
        .item   (item_reg),
        .cfg    (cfg),
        .frame  (frame),
        .drive  (drive),
        .beep   (beep),
        .button (button)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_fire)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            swing_reg  <= drive[PIN_SWING];
            pump_reg   <= drive[PIN_PUMP];
            speed_reg  <= drive[KNOB_W-1:PIN_SPD_LO];
            beep_reg   <= beep;
            done_reg   <= frame.done;
            code_reg   <= frame.code;
            error_reg  <= frame.error;
            button_reg <= button;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.swing_pin   = swing_reg;
    assign out_ch.pump_pin    = pump_reg;
    assign out_ch.speed_pins  = speed_reg;
    assign out_ch.beep        = beep_reg;
    assign out_ch.frame_done  = done_reg;
    assign out_ch.frame_code  = code_reg;
    assign out_ch.frame_error = error_reg;
    assign out_ch.button      = button_reg;

endmodule

@@ hw/rtl/irrac_cfg_regs.sv @@
module irrac_cfg_regs
    import irrac_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ZERO_CENTER: cfg_next.zero_center = cfg_data[WIN_W-1:0];
                CFG_ZERO_TOL:    cfg_next.zero_tol    = cfg_data[WIN_W-1:0];
                CFG_ONE_CENTER:  cfg_next.one_center  = cfg_data[WIN_W-1:0];
                CFG_ONE_TOL:     cfg_next.one_tol     = cfg_data[WIN_W-1:0];
                CFG_POWER_CODE:  cfg_next.power_code  = cfg_data[CODE_W-1:0];
                CFG_PUMP_CODE:   cfg_next.pump_code   = cfg_data[CODE_W-1:0];
                CFG_SWING_CODE:  cfg_next.swing_code  = cfg_data[CODE_W-1:0];
                CFG_SPEED_CODE:  cfg_next.speed_code  = cfg_data[CODE_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.zero_center <= ZERO_CENTER_RST;
            cfg_reg.zero_tol    <= ZERO_TOL_RST;
            cfg_reg.one_center  <= ONE_CENTER_RST;
            cfg_reg.one_tol     <= ONE_TOL_RST;
            cfg_reg.power_code  <= '0;
            cfg_reg.pump_code   <= '0;
            cfg_reg.swing_code  <= '0;
            cfg_reg.speed_code  <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hw/rtl/irrac_ir_decoder.sv @@
module irrac_ir_decoder
    import irrac_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  item_t       item,
    input  cfg_t        cfg,
    output frame_info_t frame
);

    logic [TIME_W-1:0]     prev_edge_reg,  prev_edge_next;
    logic [EDGE_CNT_W-1:0] edge_cnt_reg,   edge_cnt_next;
    logic [CODE_W-1:0]     code_shift_reg, code_shift_next;
    logic                  bad_reg,        bad_next;

    logic [TIME_W-1:0] interval;
    logic [TIME_W:0]   zero_diff;
    logic [TIME_W:0]   one_diff;
    logic [TIME_W-1:0] zero_abs;
    logic [TIME_W-1:0] one_abs;
    logic              is_zero;
    logic              is_one;

    // Interval against both windows; zero window wins
    assign interval  = item.edge_time_us - prev_edge_reg;
    assign zero_diff = {1'b0, interval} - {{(TIME_W+1-WIN_W){1'b0}}, cfg.zero_center};
    assign one_diff  = {1'b0, interval} - {{(TIME_W+1-WIN_W){1'b0}}, cfg.one_center};
    assign zero_abs  = zero_diff[TIME_W] ? (~zero_diff[TIME_W-1:0] + 1'b1)
                                         : zero_diff[TIME_W-1:0];
    assign one_abs   = one_diff[TIME_W] ? (~one_diff[TIME_W-1:0] + 1'b1)
                                        : one_diff[TIME_W-1:0];
    assign is_zero   = zero_abs < {{(TIME_W-WIN_W){1'b0}}, cfg.zero_tol};
    assign is_one    = one_abs  < {{(TIME_W-WIN_W){1'b0}}, cfg.one_tol};

    // Edge and frame-end handling
    always_comb
    begin
        prev_edge_next  = prev_edge_reg;
        edge_cnt_next   = edge_cnt_reg;
        code_shift_next = code_shift_reg;
        bad_next        = bad_reg;
        if (fire)
        begin
            unique case (cmd_t'(item.command))
                CMD_EDGE:
                begin
                    if (edge_cnt_reg < EDGE_CNT_W'(MAX_EDGES))
                    begin
                        if ((edge_cnt_reg != '0) && !bad_reg)
                        begin
                            priority if (is_zero)
                                code_shift_next = {code_shift_reg[CODE_W-2:0], 1'b0};
                            else if (is_one)
                                code_shift_next = {code_shift_reg[CODE_W-2:0], 1'b1};
                            else
                                bad_next = 1'b1;
                        end
                        prev_edge_next = item.edge_time_us;
                        edge_cnt_next  = edge_cnt_reg + 1'b1;
                    end
                end
                CMD_FRAME_END:
                begin
                    edge_cnt_next   = '0;
                    code_shift_next = '0;
                    bad_next        = 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_edge_reg  <= '0;
            edge_cnt_reg   <= '0;
            code_shift_reg <= '0;
            bad_reg        <= 1'b0;
        end
        else
        begin
            prev_edge_reg  <= prev_edge_next;
            edge_cnt_reg   <= edge_cnt_next;
            code_shift_reg <= code_shift_next;
            bad_reg        <= bad_next;
        end
    end

    // Frame summary, zero on other commands
    assign frame.done  = (cmd_t'(item.command) == CMD_FRAME_END);
    assign frame.code  = frame.done ? code_shift_reg : '0;
    assign frame.error = frame.done & bad_reg;

endmodule

@@ hw/rtl/irrac_appliance_ctrl.sv @@
module irrac_appliance_ctrl
    import irrac_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  item_t             item,
    input  cfg_t              cfg,
    input  frame_info_t       frame,
    output logic [KNOB_W-1:0] drive,
    output logic              beep,
    output btn_t              button
);

    logic                  fan_run_reg,    fan_run_next;
    logic [LEVEL_W-1:0]    fan_level_reg,  fan_level_next;
    logic                  swing_on_reg,   swing_on_next;
    logic                  pump_on_reg,    pump_on_next;
    logic [KNOB_POS_W-1:0] mode_knob_reg,  mode_knob_next;
    logic [KNOB_POS_W-1:0] speed_knob_reg, speed_knob_next;
    logic [KNOB_W-1:0]     drive_reg,      drive_next;

    logic [KNOB_POS_W-1:0] mode_pos;
    logic [KNOB_POS_W-1:0] speed_pos;

    // One-hot speed pins for a level, none for level zero
    function automatic logic [SPEED_W-1:0] speed_onehot(input logic [LEVEL_W-1:0] lvl);
        logic [SPEED_W-1:0] pins;
        pins = '0;
        if (lvl != '0)
            pins[lvl - 1'b1] = 1'b1;
        return pins;
    endfunction

    // Knob position decode, pins active low
    always_comb
    begin
        priority if (!item.knob_pins[0])
            mode_pos = item.knob_pins[1] ? 2'd1 : 2'd2;
        else if (!item.knob_pins[1])
            mode_pos = 2'd3;
        else
            mode_pos = 2'd0;

        priority if (!item.knob_pins[2])
            speed_pos = 2'd1;
        else if (!item.knob_pins[3])
            speed_pos = 2'd2;
        else if (!item.knob_pins[4])
            speed_pos = 2'd3;
        else
            speed_pos = 2'd0;
    end

    // Button actions and knob changes
    always_comb
    begin
        fan_run_next    = fan_run_reg;
        fan_level_next  = fan_level_reg;
        swing_on_next   = swing_on_reg;
        pump_on_next    = pump_on_reg;
        mode_knob_next  = mode_knob_reg;
        speed_knob_next = speed_knob_reg;
        drive_next      = drive_reg;
        beep            = 1'b0;
        button          = BTN_NONE;

        unique case (cmd_t'(item.command))
            CMD_FRAME_END:
            begin
                priority if (frame.code == cfg.power_code)
                begin
                    button = BTN_POWER;
                    beep   = 1'b1;
                    if (!fan_run_reg)
                    begin
                        drive_next[KNOB_W-1:PIN_SPD_LO] = speed_onehot(2'd1);
                        fan_run_next   = 1'b1;
                        fan_level_next = 2'd1;
                    end
                    else
                    begin
                        drive_next     = '0;
                        fan_run_next   = 1'b0;
                        fan_level_next = '0;
                        swing_on_next  = 1'b0;
                        pump_on_next   = 1'b0;
                    end
                end
                else if (frame.code == cfg.pump_code)
                begin
                    button               = BTN_PUMP;
                    beep                 = 1'b1;
                    pump_on_next         = !pump_on_reg;
                    drive_next[PIN_PUMP] = !pump_on_reg;
                end
                else if (frame.code == cfg.swing_code)
                begin
                    button = BTN_SWING;
                    if (swing_on_reg)
                    begin
                        swing_on_next         = 1'b0;
                        drive_next[PIN_SWING] = 1'b0;
                        beep                  = 1'b1;
                    end
                    else if (fan_run_reg)
                    begin
                        swing_on_next         = 1'b1;
                        drive_next[PIN_SWING] = 1'b1;
                        beep                  = 1'b1;
                    end
                end
                else if (frame.code == cfg.speed_code)
                begin
                    button         = BTN_SPEED;
                    beep           = 1'b1;
                    fan_level_next = (fan_level_reg == 2'd3) ? 2'd1 : fan_level_reg + 1'b1;
                    drive_next[KNOB_W-1:PIN_SPD_LO] = speed_onehot(fan_level_next);
                    fan_run_next   = 1'b1;
                end
                else
                begin
                    // Unknown code: no action
                    button = BTN_NONE;
                end
            end
            CMD_KNOB:
            begin
                // Mode knob first
                if (mode_pos != mode_knob_reg)
                begin
                    if (mode_pos == 2'd0)
                    begin
                        drive_next[PIN_SWING] = 1'b0;
                        drive_next[PIN_PUMP]  = 1'b0;
                    end
                    else
                    begin
                        swing_on_next         = (mode_pos != 2'd3);
                        pump_on_next          = (mode_pos != 2'd1);
                        drive_next[PIN_SWING] = (mode_pos != 2'd3);
                        drive_next[PIN_PUMP]  = (mode_pos != 2'd1);
                        beep                  = 1'b1;
                    end
                end
                mode_knob_next = mode_pos;

                // Then the speed knob
                if (speed_pos != speed_knob_reg)
                begin
                    fan_level_next = speed_pos;
                    drive_next[KNOB_W-1:PIN_SPD_LO] = speed_onehot(speed_pos);
                    fan_run_next   = (speed_pos != 2'd0);
                    if (speed_pos != 2'd0)
                        beep = 1'b1;
                end
                speed_knob_next = speed_pos;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fan_run_reg    <= 1'b0;
            fan_level_reg  <= '0;
            swing_on_reg   <= 1'b0;
            pump_on_reg    <= 1'b0;
            mode_knob_reg  <= '0;
            speed_knob_reg <= '0;
            drive_reg      <= '0;
        end
        else if (fire)
        begin
            fan_run_reg    <= fan_run_next;
            fan_level_reg  <= fan_level_next;
            swing_on_reg   <= swing_on_next;
            pump_on_reg    <= pump_on_next;
            mode_knob_reg  <= mode_knob_next;
            speed_knob_reg <= speed_knob_next;
            drive_reg      <= drive_next;
        end
    end

    assign drive = drive_next;

endmodule

@@ hw/rtl/irrac_checker.sv @@
module irrac_checker
    import irrac_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic [SPEED_W-1:0] speed_pins,
    input logic               beep,
    input logic               frame_done,
    input logic [CODE_W-1:0]  frame_code,
    input logic               frame_error,
    input logic [BTN_W-1:0]   button
);

    // Stalled result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(frame_code) && $stable(button)
            && $stable(speed_pins) && $stable(beep))
        else $error("result changed while stalled");

    // At most one fan speed drive is active
    a_speed_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0(speed_pins))
        else $error("more than one speed pin driven");

    // Frame fields are quiet on items that do not end a frame
    a_frame_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_done |-> frame_code == '0 && !frame_error
            && button == BTN_NONE)
        else $error("frame fields set outside frame end");

    // Power, pump and speed buttons always beep
    a_button_beep: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (button == BTN_POWER || button == BTN_PUMP || button == BTN_SPEED)
            |-> beep)
        else $error("button action without beep");

endmodule

bind ir_remote_appliance_controller_unit irrac_checker u_irrac_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .speed_pins  (out_ch.speed_pins),
    .beep        (out_ch.beep),
    .frame_done  (out_ch.frame_done),
    .frame_code  (out_ch.frame_code),
    .frame_error (out_ch.frame_error),
    .button      (out_ch.button)
);
